// ===== design/sbet_pkg.sv =====
package sbet_pkg;

  // Field widths of the channels
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MODULE_W = 5;
  localparam int unsigned SENSOR_W = 5;
  localparam int unsigned SLOT_W   = 7;

  // Register reset and sensor numbering
  localparam logic [MODULE_W-1:0] MODULE_COUNT_RESET = 5'd5;
  localparam logic [MODULE_W-1:0] MODULE_FIRST       = 5'd1;
  localparam logic [SENSOR_W-1:0] SENSOR_BASE_LO     = 5'd1;
  localparam logic [SENSOR_W-1:0] SENSOR_BASE_HI     = 5'd9;

  // One byte's worth of work handed to the event emitter
  typedef struct packed {
    logic [BYTE_W-1:0]   mask;
    logic [MODULE_W-1:0] module_number;
    logic                half;
  } sbet_job_t;

endpackage

// ===== design/sbet_if.sv =====
interface sbet_in_if
  import sbet_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] sensor_byte;

  modport source (output valid, output sensor_byte, input ready);
  modport sink   (input valid, input sensor_byte, output ready);
endinterface

interface sbet_out_if
  import sbet_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [MODULE_W-1:0] module_number;
  logic [SENSOR_W-1:0] sensor_number;
  logic [SLOT_W-1:0]   history_slot;
  logic                last_event;

  modport source (output valid, output module_number, output sensor_number,
                  output history_slot, output last_event, input ready);
  modport sink   (input valid, input module_number, input sensor_number,
                  input history_slot, input last_event, output ready);
endinterface

interface sbet_cfg_if
  import sbet_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [MODULE_W-1:0] module_count;

  modport source (output valid, output module_count, input ready);
  modport sink   (input valid, input module_count, output ready);
endinterface

// ===== design/sensor_byte_edge_tracker.sv =====
// A word's events pass the stage-1 and pending-bit registers to the output register.
// Throughput: a word is accepted every cycle while the emitter keeps up; the emitter
//   sends one event word per cycle while out_ch is ready, one per new bit of the byte.
// The reading store is read and written in the accept cycle (read-before-write port).
// Reset (rst_n, synchronous): counters to module 1 / first byte, module_count to 5,
//   stored readings marked unwritten at once; no clearing pass.
module sensor_byte_edge_tracker
  import sbet_pkg::*;
#(
  parameter int unsigned MAX_MODULES   = 32,
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  sbet_in_if.sink    in_ch,
  sbet_out_if.source out_ch,
  sbet_cfg_if.sink   cfg_ch
);

  localparam int unsigned DEPTH  = 2 * MAX_MODULES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned MIDX_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam logic [MIDX_W-1:0] MSLOT_ONE  = MIDX_W'((MAX_MODULES > 1) ? 1 : 0);
  localparam logic [MIDX_W-1:0] MSLOT_LAST = MIDX_W'(MAX_MODULES - 1);

  logic [MODULE_W-1:0] module_count_r;
  logic [MODULE_W-1:0] module_r;
  logic [MIDX_W-1:0]   mslot_r;
  logic                half_r;
  logic                st1_valid_r;
  logic [BYTE_W-1:0]   st1_byte_r;
  logic [MODULE_W-1:0] st1_module_r;
  logic                st1_half_r;

  logic [MODULE_W-1:0] limit;
  logic                in_accept;
  logic [ADDR_W-1:0]   addr;
  logic [BYTE_W-1:0]   old_byte;
  sbet_job_t           job;
  logic                job_ready;

  // Configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      module_count_r <= MODULE_COUNT_RESET;
    end else if (cfg_ch.valid) begin
      module_count_r <= cfg_ch.module_count;
    end
  end

  assign in_ch.ready = !st1_valid_r || job_ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign limit       = (module_count_r == '0) ? MODULE_FIRST : module_count_r;
  assign addr        = ADDR_W'({mslot_r, half_r});

  // Advance the poll position on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      module_r <= MODULE_FIRST;
      mslot_r  <= MSLOT_ONE;
      half_r   <= 1'b0;
    end else if (in_accept) begin
      half_r <= !half_r;
      if (half_r) begin
        if (module_r >= limit) begin
          module_r <= MODULE_FIRST;
          mslot_r  <= MSLOT_ONE;
        end else begin
          module_r <= module_r + 1'b1;
          mslot_r  <= (mslot_r == MSLOT_LAST) ? '0 : mslot_r + 1'b1;
        end
      end
    end
  end

  sbet_reading_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_accept),
    .addr  (addr),
    .wdata (in_ch.sensor_byte),
    .rdata (old_byte)
  );

  // Hold the word while its old reading comes back from the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      st1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      st1_byte_r   <= in_ch.sensor_byte;
      st1_module_r <= module_r;
      st1_half_r   <= half_r;
    end
  end

  // Newly set bits of this byte
  always_comb begin
    job.mask          = st1_byte_r & ~old_byte;
    job.module_number = st1_module_r;
    job.half          = st1_half_r;
  end

  sbet_event_emitter #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (st1_valid_r),
    .job       (job),
    .job_ready (job_ready),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_half_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_accept |=> half_r != $past(half_r))
    else $error("half counter did not toggle on an accepted word");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && st1_valid_r && !job_ready |=> st1_valid_r && $stable(st1_byte_r))
    else $error("pending word lost while the emitter was busy");

  a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.module_number != '0 && out_ch.sensor_number != '0)
    else $error("event word with zero module or sensor number");
`endif

endmodule

// ===== design/sbet_reading_store.sv =====
module sbet_reading_store
  import sbet_pkg::*;
#(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] readings_mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_valid_r;

  // Read the old reading and write the new one in the same cycle
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r          <= readings_mem[addr];
      readings_mem[addr] <= wdata;
    end
  end

  // Mark entries written since reset; an unmarked entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else if (en) begin
      rd_valid_r    <= valid_r[addr];
      valid_r[addr] <= 1'b1;
    end
  end

  assign rdata = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== design/sbet_event_emitter.sv =====
module sbet_event_emitter
  import sbet_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  sbet_job_t  job,
  output logic       job_ready,
  sbet_out_if.source out_ch
);

  localparam int unsigned HIW = $clog2(HISTORY_DEPTH);

  logic [BYTE_W-1:0]   mask_r;
  logic [BYTE_W-1:0]   mask_nxt;
  logic [MODULE_W-1:0] module_r;
  logic                half_r;
  logic [HIW-1:0]      hidx_r;
  logic                out_valid_r;
  logic [MODULE_W-1:0] out_module_r;
  logic [SENSOR_W-1:0] out_sensor_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_last_r;

  logic [2:0]          sel;
  logic [BYTE_W-1:0]   rest;
  logic                step;
  logic                load;
  logic [SENSOR_W-1:0] sensor;

  logic [MODULE_W+SENSOR_W-1:0] history_mem [HISTORY_DEPTH];

  // Pick the highest pending bit and work out what is left behind it
  always_comb begin
    sel = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (mask_r[i]) sel = 3'(i);
    end
    rest   = mask_r & ~(8'b1 << sel);
    step   = (mask_r != '0) && (!out_valid_r || out_ch.ready);
    load   = (mask_r == '0) || (step && (rest == '0));
    sensor = (half_r ? SENSOR_BASE_HI : SENSOR_BASE_LO) + {2'b00, ~sel};
    if (load) begin
      mask_nxt = job_valid ? job.mask : '0;
    end else if (step) begin
      mask_nxt = rest;
    end else begin
      mask_nxt = mask_r;
    end
  end

  assign job_ready = load;

  // Hold the pending bits of the current byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      module_r <= job.module_number;
      half_r   <= job.half;
    end
  end

  // Advance the history write position once per event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hidx_r <= '0;
    end else if (step) begin
      hidx_r <= (hidx_r == HIW'(HISTORY_DEPTH - 1)) ? '0 : hidx_r + 1'b1;
    end
  end

  // Log each event in the history ring
  always_ff @(posedge clk) begin
    if (step) begin
      history_mem[hidx_r] <= {module_r, sensor};
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_module_r <= module_r;
      out_sensor_r <= sensor;
      out_slot_r   <= SLOT_W'(hidx_r);
      out_last_r   <= (rest == '0);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.module_number = out_module_r;
  assign out_ch.sensor_number = out_sensor_r;
  assign out_ch.history_slot  = out_slot_r;
  assign out_ch.last_event    = out_last_r;

endmodule
